### sv/mmu_pkg.sv
// Package with shared widths, command codes and types of the matrix multiply unit.
`default_nettype none
package mmu_pkg;

  localparam int CMD_W   = 2;
  localparam int IDX_IN_W = 3;
  localparam int VAL_W   = 16;
  localparam int PROD_W  = 35;
  localparam int ACC_W   = PROD_W + 1;
  localparam int DIM_REG_W = 4;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [CMD_W-1:0] CMD_WRITE_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

  localparam logic [1:0] REG_A_ROWS = 2'd0;
  localparam logic [1:0] REG_A_COLS = 2'd1;
  localparam logic [1:0] REG_B_ROWS = 2'd2;
  localparam logic [1:0] REG_B_COLS = 2'd3;

  localparam logic [DIM_REG_W-1:0] DIM_RESET = 4'd8;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

endpackage
`default_nettype wire

### sv/mmu_if.sv
// Stream interfaces for the request and result channels.
`default_nettype none
interface mmu_req_if;
  import mmu_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic [IDX_IN_W-1:0]     row_index;
  logic [IDX_IN_W-1:0]     col_index;
  logic signed [VAL_W-1:0] entry_value;
  modport source (output valid, command, row_index, col_index, entry_value, input ready);
  modport sink (input valid, command, row_index, col_index, entry_value, output ready);
endinterface

interface mmu_res_if;
  import mmu_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [IDX_IN_W-1:0]      out_row;
  logic [IDX_IN_W-1:0]      out_col;
  logic signed [PROD_W-1:0] product_value;
  logic                     size_mismatch;
  logic                     last;
  modport source (output valid, out_row, out_col, product_value, size_mismatch, last,
                  input ready);
  modport sink (input valid, out_row, out_col, product_value, size_mismatch, last,
                output ready);
endinterface
`default_nettype wire

### sv/mmu_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mmu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

### sv/mmu_cell.sv
// One accumulator cell of the rotating chain of partial sums.
`default_nettype none
module mmu_cell
  import mmu_pkg::*;
(
  input  wire logic                    clk,
  input  wire cell_ctl_t               ctl,
  input  wire logic signed [ACC_W-1:0] prev,
  input  wire logic signed [ACC_W-1:0] addend,
  output logic signed [ACC_W-1:0]      acc
);
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      acc <= (ctl.clear ? '0 : prev) + addend;
    end
  end
endmodule
`default_nettype wire

### sv/matrix_multiply_unit.sv
// Top level of the matrix multiply unit: stores, sequencer, multiplier and cell chain.
// Write transactions are accepted back to back while the unit is idle.
// A compute transaction performs one multiply-accumulate per cycle while results are
// taken, through the single read port of each store.
// Results stall the whole pipeline when not taken. Reset is synchronous; it marks all
// entries of both stores as unwritten (read as zero) and sets all sizes to eight.
`default_nettype none
module matrix_multiply_unit
  import mmu_pkg::*;
#(
  parameter int MAX_DIM = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  mmu_req_if.sink                 request,
  mmu_res_if.source               result,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready
);
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_W  = $clog2(MAX_DIM);
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int CMP_W  = 8;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_MISM  = 2'd3;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             first;
    logic             emit;
    logic             last;
  } tag_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_REG_W-1:0] r);
    logic [DIM_W-1:0] v;
    v = DIM_W'(r);
    if (r == '0) begin
      v = DIM_W'(1);
    end else if (32'(r) > MAX_DIM) begin
      v = DIM_W'(MAX_DIM);
    end
    return v;
  endfunction

  logic [DIM_REG_W-1:0] a_rows, a_cols, b_rows, b_cols;
  logic [DIM_W-1:0] ar, ac, br, bc;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows <= DIM_RESET;
      a_cols <= DIM_RESET;
      b_rows <= DIM_RESET;
      b_cols <= DIM_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_A_ROWS: a_rows <= pwdata[DIM_REG_W-1:0];
        REG_A_COLS: a_cols <= pwdata[DIM_REG_W-1:0];
        REG_B_ROWS: b_rows <= pwdata[DIM_REG_W-1:0];
        REG_B_COLS: b_cols <= pwdata[DIM_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_A_ROWS: prdata = PDATA_W'(a_rows);
      REG_A_COLS: prdata = PDATA_W'(a_cols);
      REG_B_ROWS: prdata = PDATA_W'(b_rows);
      REG_B_COLS: prdata = PDATA_W'(b_cols);
      default:    prdata = '0;
    endcase
  end

  assign ar = eff_dim(a_rows);
  assign ac = eff_dim(a_cols);
  assign br = eff_dim(b_rows);
  assign bc = eff_dim(b_cols);

  logic [1:0] state;
  logic [IDX_W-1:0] i_cnt, k_cnt, j_cnt;
  logic en, req_acc, wr_a, wr_b, issue;
  logic [ADDR_W-1:0] waddr, a_raddr, b_raddr;
  logic [DEPTH-1:0] a_vld, b_vld;
  logic a_ok, b_ok;
  logic [VAL_W-1:0] a_data, b_data;
  tag_t t1, t2, t0;
  logic signed [ACC_W-1:0] prod2;
  logic i_last, k_last, j_last;

  assign en = !(result.valid && !result.ready);
  assign request.ready = (state == S_IDLE);
  assign req_acc = request.valid && request.ready;

  assign wr_a = req_acc && request.command == CMD_WRITE_A
                && CMP_W'(request.row_index) < CMP_W'(ar)
                && CMP_W'(request.col_index) < CMP_W'(ac);
  assign wr_b = req_acc && request.command == CMD_WRITE_B
                && CMP_W'(request.row_index) < CMP_W'(br)
                && CMP_W'(request.col_index) < CMP_W'(bc);
  assign waddr = ADDR_W'(32'(request.row_index) * MAX_DIM + 32'(request.col_index));

  assign a_raddr = ADDR_W'(32'(i_cnt) * MAX_DIM + 32'(k_cnt));
  assign b_raddr = ADDR_W'(32'(k_cnt) * MAX_DIM + 32'(j_cnt));
  assign issue = (state == S_RUN) && en;

  assign i_last = DIM_W'(i_cnt) == ar - DIM_W'(1);
  assign k_last = DIM_W'(k_cnt) == ac - DIM_W'(1);
  assign j_last = j_cnt == IDX_W'(MAX_DIM - 1);

  mmu_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) a_ram (
    .clk(clk), .we(wr_a), .waddr(waddr), .wdata(request.entry_value),
    .re(issue), .raddr(a_raddr), .rdata(a_data)
  );

  mmu_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) b_ram (
    .clk(clk), .we(wr_b), .waddr(waddr), .wdata(request.entry_value),
    .re(issue), .raddr(b_raddr), .rdata(b_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= '0;
      b_vld <= '0;
    end else begin
      if (wr_a) begin
        a_vld[waddr] <= 1'b1;
      end
      if (wr_b) begin
        b_vld[waddr] <= 1'b1;
      end
    end
  end

  always_comb begin
    t0.valid = 1'b1;
    t0.row   = i_cnt;
    t0.col   = j_cnt;
    t0.first = (k_cnt == '0);
    t0.emit  = k_last && CMP_W'(j_cnt) < CMP_W'(bc);
    t0.last  = i_last && DIM_W'(j_cnt) == bc - DIM_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      i_cnt <= '0;
      k_cnt <= '0;
      j_cnt <= '0;
      t1    <= '0;
      t2    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_acc && request.command == CMD_COMPUTE) begin
            i_cnt <= '0;
            k_cnt <= '0;
            j_cnt <= '0;
            state <= (ac != br) ? S_MISM : S_RUN;
          end
        end
        S_RUN: begin
          if (en) begin
            j_cnt <= j_last ? '0 : j_cnt + IDX_W'(1);
            if (j_last) begin
              k_cnt <= k_last ? '0 : k_cnt + IDX_W'(1);
              if (k_last) begin
                i_cnt <= i_cnt + IDX_W'(1);
                if (i_last) begin
                  state <= S_DRAIN;
                end
              end
            end
          end
        end
        S_DRAIN: begin
          if (!t1.valid && !t2.valid) begin
            state <= S_IDLE;
          end
        end
        S_MISM: begin
          if (en) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (en) begin
        t1 <= issue ? t0 : '0;
        t2 <= t1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      a_ok <= a_vld[a_raddr];
      b_ok <= b_vld[b_raddr];
    end
    if (en) begin
      prod2 <= ACC_W'($signed(a_ok ? a_data : '0) * $signed(b_ok ? b_data : '0));
    end
  end

  logic signed [ACC_W-1:0] acc [MAX_DIM];
  cell_ctl_t ctl_head, ctl_rest;

  assign ctl_head.shift = en && t2.valid;
  assign ctl_head.clear = t2.first;
  assign ctl_rest.shift = en && t2.valid;
  assign ctl_rest.clear = 1'b0;

  mmu_cell head_cell (
    .clk(clk), .ctl(ctl_head), .prev(acc[MAX_DIM-1]), .addend(prod2), .acc(acc[0])
  );

  for (genvar n = 1; n < MAX_DIM; n++) begin : g_chain
    mmu_cell chain_cell (
      .clk(clk), .ctl(ctl_rest), .prev(acc[n-1]), .addend('0), .acc(acc[n])
    );
  end

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (PROD_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  logic signed [ACC_W-1:0] sum;
  logic signed [PROD_W-1:0] sat;

  assign sum = (t2.first ? '0 : acc[MAX_DIM-1]) + prod2;

  always_comb begin
    if (sum > SAT_HI) begin
      sat = PROD_W'(SAT_HI);
    end else if (sum < SAT_LO) begin
      sat = PROD_W'(SAT_LO);
    end else begin
      sat = PROD_W'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en && state == S_MISM) begin
      result.valid <= 1'b1;
    end else if (en && t2.valid && t2.emit) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && state == S_MISM) begin
      result.out_row       <= '0;
      result.out_col       <= '0;
      result.product_value <= '0;
      result.size_mismatch <= 1'b1;
      result.last          <= 1'b1;
    end else if (en && t2.valid && t2.emit) begin
      result.out_row       <= IDX_IN_W'(t2.row);
      result.out_col       <= IDX_IN_W'(t2.col);
      result.product_value <= sat;
      result.size_mismatch <= 1'b0;
      result.last          <= t2.last;
    end
  end
endmodule
`default_nettype wire
